### src/tpc_pkg.sv
// Shared types and constants for the terrain pattern classifier.
package tpc_pkg;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA    = 2'd2;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned CODE_W = 13;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned NUM_RAYS = 8;
  localparam int unsigned RAY_W = 3;
  localparam int unsigned POS_W = 6;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  typedef logic [1:0] digit_t;
  localparam digit_t DIG_LOWER  = 2'd0;
  localparam digit_t DIG_EQUAL  = 2'd1;
  localparam digit_t DIG_HIGHER = 2'd2;

  // Per-ray step: row delta and column delta in {-1,0,1}, as 2-bit codes
  typedef logic [1:0] step_t;
  localparam step_t STEP_ZERO = 2'd0;
  localparam step_t STEP_POS  = 2'd1;
  localparam step_t STEP_NEG  = 2'd2;

  function automatic step_t ray_dr(input logic [RAY_W-1:0] k);
    step_t s;
    case (k)
      3'd1, 3'd2, 3'd3: s = STEP_POS;
      3'd5, 3'd6, 3'd7: s = STEP_NEG;
      default:          s = STEP_ZERO;
    endcase
    return s;
  endfunction

  function automatic step_t ray_dc(input logic [RAY_W-1:0] k);
    step_t s;
    case (k)
      3'd0, 3'd1, 3'd7: s = STEP_POS;
      3'd3, 3'd4, 3'd5: s = STEP_NEG;
      default:          s = STEP_ZERO;
    endcase
    return s;
  endfunction

  // Status from the pattern reducer
  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] code;
  } pat_status_t;
endpackage

### src/terrain_pattern_classifier.sv
// Top level: elevation grid store, ray walker sequencer and shared multiplier.
//
// Usage: drive start with func=0 to write one elevation sample at (row,col);
// func=1 classifies that pixel. An item is taken when start is high and busy
// is low. A write gives no result and holds busy for one cycle, so the next
// item can be taken once busy drops. A classify gives one result, shown
// for one cycle with out_valid high; the receiver cannot stall, so it must
// take it then.
// A border pixel gives its result straight after the border check, a
// missing-data center after the center read. An interior pixel walks eight
// rays over at most 2*(rows-1)+2*(cols-1) cells (252 on a 64x64 grid); a
// counted cell after the first on its ray needs four products on the one
// multiplier, each ray ends with its sign sum, and the pattern reduction
// follows the last ray. busy drops the cycle after the result. The single
// read port of the grid store and the one shared multiplier set how long a
// classify takes. Reset clears the sequencer and sets row_count=64,
// col_count=64, nodata_elevation=-9999; the grid store is not cleared.
// cfg_* writes take effect at once and are meant only while busy is low.
module terrain_pattern_classifier #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int ELEV_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [tpc_pkg::POS_W-1:0]     in_row,
  input  logic [tpc_pkg::POS_W-1:0]     in_col,
  input  logic signed [23:0]            in_elevation,
  input  logic                          cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [tpc_pkg::CODE_W-1:0]    out_pattern_code,
  output logic [tpc_pkg::CNT_W-1:0]     out_higher_count,
  output logic [tpc_pkg::CNT_W-1:0]     out_lower_count,
  output logic                          out_no_data
);
  import tpc_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int EW = ELEV_WIDTH;
  // dz spans EW+1 bits; distance fits in max(RW,CW)+1 unsigned
  localparam int DW = EW + 1;
  localparam int XW = (RW > CW ? RW : CW) + 2;
  localparam int PW = DW + XW;
  localparam int CNTW = 11;

  typedef enum logic [3:0] {
    S_IDLE, S_CENTER_RD, S_CENTER, S_RAY_START, S_STEP, S_CELL,
    S_CMP_MN, S_MN_PROD, S_FINAL, S_FINAL2, S_PATTERN, S_DONE
  } state_t;

  // configuration
  logic [6:0]          row_count_r, col_count_r;
  logic signed [EW-1:0] nodata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 7'd64;
      col_count_r <= 7'd64;
      nodata_r    <= EW'(-24'sd9999);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_data[6:0];
        CFG_COL_COUNT: col_count_r <= cfg_data[6:0];
        CFG_NODATA:    nodata_r    <= EW'(signed'(cfg_data));
        default: ;
      endcase
    end
  end

  // effective rows/cols (saturated), as CNTW-bit values
  logic [CNTW-1:0] rows_eff, cols_eff;
  always_comb begin
    rows_eff = (CNTW'(row_count_r) > CNTW'(MAX_ROWS)) ? CNTW'(MAX_ROWS) : CNTW'(row_count_r);
    cols_eff = (CNTW'(col_count_r) > CNTW'(MAX_COLS)) ? CNTW'(MAX_COLS) : CNTW'(col_count_r);
  end

  // grid store
  logic signed [EW-1:0] mem [DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic signed [EW-1:0] mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // sequencer registers
  state_t               state_r, state_nxt;
  logic [CNTW-1:0]      r0_r, r0_nxt, c0_r, c0_nxt;
  logic [CNTW-1:0]      r_r, r_nxt, c_r, c_nxt;
  logic [XW-1:0]        a_r, a_nxt;
  logic [RAY_W-1:0]     k_r, k_nxt;
  logic signed [EW-1:0] z0_r, z0_nxt;
  logic [DW-1:0]        best_r, best_nxt;
  logic signed [DW-1:0] mxz_r, mxz_nxt, mnz_r, mnz_nxt, dz_r, dz_nxt;
  logic [XW-1:0]        mxa_r, mxa_nxt, mna_r, mna_nxt;
  logic                 any_r, any_nxt;
  logic [15:0]          dig_r, dig_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt, lo_r, lo_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic                 ovalid_r, ovalid_nxt, ond_r, ond_nxt;
  logic                 wr_pend_r, wr_pend_nxt;
  logic                 pat_go;
  pat_status_t          pat;

  // shared multiplier: one signed dz times one distance per cycle
  logic signed [DW-1:0] mul_a;
  logic [XW-1:0]        mul_b;
  logic signed [PW-1:0] mul_p;
  assign mul_p = PW'(mul_a) * signed'({1'b0, mul_b[XW-2:0]});

  tpc_pattern_min u_pat (
    .clk(clk), .rst_n(rst_n), .go(pat_go), .digits(dig_r), .status(pat)
  );

  function automatic logic [CNTW-1:0] stepv(input logic [CNTW-1:0] v, input step_t s);
    logic [CNTW-1:0] o;
    case (s)
      STEP_POS: o = v + CNTW'(1);
      STEP_NEG: o = v - CNTW'(1);
      default:  o = v;
    endcase
    return o;
  endfunction

  logic [CNTW-1:0] r_step, c_step;
  logic            out_of_grid;
  logic signed [DW-1:0] dz_cur;
  logic [DW-1:0]        adz_cur;
  assign r_step = stepv(r_r, ray_dr(k_r));
  assign c_step = stepv(c_r, ray_dc(k_r));
  // wraparound below zero shows as a large value
  assign out_of_grid = (r_step >= rows_eff) || (c_step >= cols_eff);
  assign dz_cur  = DW'(mem_rdata_r) - DW'(z0_r);
  assign adz_cur = dz_cur[DW-1] ? DW'(-dz_cur) : DW'(dz_cur);

  always_comb begin
    logic signed [PW-1:0] s;
    digit_t d;
    state_nxt   = state_r;
    r0_nxt = r0_r; c0_nxt = c0_r; r_nxt = r_r; c_nxt = c_r;
    a_nxt = a_r; k_nxt = k_r; z0_nxt = z0_r; best_nxt = best_r;
    mxz_nxt = mxz_r; mnz_nxt = mnz_r; dz_nxt = dz_r;
    mxa_nxt = mxa_r; mna_nxt = mna_r; any_nxt = any_r;
    dig_nxt = dig_r; hi_nxt = hi_r; lo_nxt = lo_r; prod_nxt = prod_r;
    ovalid_nxt = 1'b0; ond_nxt = ond_r; wr_pend_nxt = 1'b0;
    pat_go = 1'b0;
    mem_we = 1'b0;
    mem_waddr = {RW'(in_row), CW'(in_col)};
    mem_wdata = EW'(in_elevation);
    mem_raddr = {r_r[RW-1:0], c_r[CW-1:0]};
    mul_a = dz_r; mul_b = mxa_r;
    s = '0; d = DIG_EQUAL;
    case (state_r)
      S_IDLE: begin
        if (start && !wr_pend_r) begin
          if (in_func == FUNC_WRITE) begin
            if (CNTW'(in_row) < CNTW'(MAX_ROWS) && CNTW'(in_col) < CNTW'(MAX_COLS))
              mem_we = 1'b1;
            wr_pend_nxt = 1'b1;
          end else begin
            r0_nxt = CNTW'(in_row); c0_nxt = CNTW'(in_col);
            r_nxt = CNTW'(in_row);  c_nxt = CNTW'(in_col);
            state_nxt = S_CENTER_RD;
          end
        end
      end
      S_CENTER_RD: begin
        if (r0_r < CNTW'(1) || c0_r < CNTW'(1) || r0_r + CNTW'(1) >= rows_eff ||
            c0_r + CNTW'(1) >= cols_eff) begin
          ovalid_nxt = 1'b1; ond_nxt = 1'b1; dig_nxt = '0; hi_nxt = '0; lo_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CENTER;
        end
      end
      S_CENTER: begin
        z0_nxt = mem_rdata_r;
        if (mem_rdata_r == nodata_r) begin
          ovalid_nxt = 1'b1; ond_nxt = 1'b1; dig_nxt = '0; hi_nxt = '0; lo_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          k_nxt = '0; hi_nxt = '0; lo_nxt = '0; dig_nxt = '0;
          state_nxt = S_RAY_START;
        end
      end
      S_RAY_START: begin
        r_nxt = r0_r; c_nxt = c0_r; a_nxt = '0;
        best_nxt = '0; any_nxt = 1'b0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (out_of_grid) begin
          // mnz*mxa for the sign sum of this ray
          mul_a = mnz_r; mul_b = mxa_r;
          prod_nxt = mul_p;
          state_nxt = S_FINAL;
        end else begin
          // read of the next cell issues here
          mem_raddr = {r_step[RW-1:0], c_step[CW-1:0]};
          r_nxt = r_step; c_nxt = c_step; a_nxt = a_r + XW'(1);
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        state_nxt = S_CMP_MN;
        dz_nxt = dz_cur;
        if (mem_rdata_r == nodata_r || adz_cur <= best_r) begin
          state_nxt = S_STEP;
        end else begin
          best_nxt = adz_cur;
          if (!any_r) begin
            mxz_nxt = dz_cur; mxa_nxt = a_r; mnz_nxt = dz_cur; mna_nxt = a_r;
            any_nxt = 1'b1;
            state_nxt = S_STEP;
          end else begin
            // dz*mxa held for next compare
            mul_a = dz_cur; mul_b = mxa_r;
            prod_nxt = mul_p;
          end
        end
      end
      S_CMP_MN: begin
        // prod_r = dz*mxa ; this cycle: mxz*a
        mul_a = mxz_r; mul_b = a_r;
        if (prod_r > mul_p) begin
          mxz_nxt = dz_r; mxa_nxt = a_r;
        end
        state_nxt = S_MN_PROD;
      end
      S_MN_PROD: begin
        mul_a = dz_r; mul_b = mna_r;
        prod_nxt = mul_p;
        state_nxt = S_FINAL2;
      end
      S_FINAL2: begin
        // prod_r = dz*mna ; this cycle: mnz*a
        mul_a = mnz_r; mul_b = a_r;
        if (prod_r < mul_p) begin
          mnz_nxt = dz_r; mna_nxt = a_r;
        end
        state_nxt = S_STEP;
      end
      S_FINAL: begin
        d = DIG_EQUAL;
        if (any_r) begin
          mul_a = mxz_r; mul_b = mna_r;
          s = mul_p + prod_r;
          if (s > 0) d = DIG_HIGHER;
          else if (s < 0) d = DIG_LOWER;
        end
        dig_nxt[2*k_r +: 2] = d;
        if (d == DIG_HIGHER) hi_nxt = hi_r + CNT_W'(1);
        if (d == DIG_LOWER)  lo_nxt = lo_r + CNT_W'(1);
        k_nxt = k_r + RAY_W'(1);
        if (k_r == RAY_W'(NUM_RAYS - 1)) begin
          pat_go = 1'b1;
          state_nxt = S_PATTERN;
        end else begin
          state_nxt = S_RAY_START;
        end
      end
      S_PATTERN: begin
        if (pat.done) begin
          ovalid_nxt = 1'b1; ond_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0; wr_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt; wr_pend_r <= wr_pend_nxt;
    end
    r0_r <= r0_nxt; c0_r <= c0_nxt; r_r <= r_nxt; c_r <= c_nxt;
    a_r <= a_nxt; k_r <= k_nxt; z0_r <= z0_nxt; best_r <= best_nxt;
    mxz_r <= mxz_nxt; mxa_r <= mxa_nxt; dz_r <= dz_nxt; any_r <= any_nxt;
    mnz_r <= mnz_nxt; mna_r <= mna_nxt;
    dig_r <= dig_nxt; hi_r <= hi_nxt; lo_r <= lo_nxt; ond_r <= ond_nxt;
    prod_r <= prod_nxt;
  end

  assign busy             = (state_r != S_IDLE) || wr_pend_r;
  assign out_valid        = ovalid_r;
  assign out_no_data      = ond_r;
  assign out_pattern_code = ond_r ? '0 : pat.code;
  assign out_higher_count = hi_r;
  assign out_lower_count  = lo_r;
endmodule

### src/tpc_pattern_min.sv
// Rotation/mirror minimum of the eight-digit base-3 code, one candidate a cycle.
module tpc_pattern_min (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [15:0]            digits,
  output tpc_pkg::pat_status_t   status
);
  import tpc_pkg::*;

  logic [3:0]        cand_r, cand_nxt;
  logic              run_r, run_nxt;
  logic [CODE_W-1:0] best_r, best_nxt;
  logic [CODE_W-1:0] code;
  logic              done_r, done_nxt;

  // candidate bit 3 picks mirror, bits 2:0 the rotation
  always_comb begin
    logic [2:0] idx;
    logic [1:0] d;
    code = '0;
    for (int i = 7; i >= 0; i--) begin
      if (cand_r[3]) idx = 3'(7 - i) + cand_r[2:0];
      else           idx = 3'(i) + cand_r[2:0];
      d = digits[2*idx +: 2];
      code = CODE_W'(code * 3) + CODE_W'(d);
    end
  end

  always_comb begin
    run_nxt  = run_r;
    cand_nxt = cand_r;
    best_nxt = best_r;
    done_nxt = 1'b0;
    if (go) begin
      run_nxt  = 1'b1;
      cand_nxt = '0;
      best_nxt = '1;
    end else if (run_r) begin
      if (code < best_r) best_nxt = code;
      cand_nxt = cand_r + 4'd1;
      if (cand_r == 4'd15) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cand_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cand_r <= cand_nxt;
    end
    best_r <= best_nxt;
  end

  assign status.done = done_r;
  assign status.code = best_r;
endmodule

### bench/tb_terrain_pattern_classifier.sv
// Testbench for terrain_pattern_classifier: scoreboard with geomorphon predictor.
`timescale 1ns / 1ps

module tb_terrain_pattern_classifier;
  import tpc_pkg::*;

  localparam int GRID_DIM = 64;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  higher;
    logic [CNT_W-1:0]  lower;
    logic              no_data;
  } terrain_result_t;

  class tpc_scoreboard;
    int grid[GRID_DIM*GRID_DIM];
    int row_cfg;
    int col_cfg;
    int nodata_elev;
    terrain_result_t pending[$];
    int errors;

    function new();
      row_cfg = 64;
      col_cfg = 64;
      nodata_elev = -9999;
      errors = 0;
      foreach (grid[i]) grid[i] = 0;
    endfunction

    function int eff_rows();
      return (row_cfg > GRID_DIM) ? GRID_DIM : row_cfg;
    endfunction

    function int eff_cols();
      return (col_cfg > GRID_DIM) ? GRID_DIM : col_cfg;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ROW_COUNT: row_cfg = int'(data[6:0]);
        CFG_COL_COUNT: col_cfg = int'(data[6:0]);
        CFG_NODATA:    nodata_elev = int'(signed'(data[23:0]));
        default: ;
      endcase
    endfunction

    function digit_t ray_sign(int r0, int c0, int k);
      int dr, dc, a, r, c;
      longint z0, z, dz, best, mxz, mxa, mnz, mna, s;
      bit any;
      dr = (k >= 1 && k <= 3) ? 1 : ((k >= 5) ? -1 : 0);
      dc = (k == 0 || k == 1 || k == 7) ? 1 : ((k >= 3 && k <= 5) ? -1 : 0);
      z0 = grid[r0*GRID_DIM + c0];
      best = 0; mxz = 0; mxa = 1; mnz = 0; mna = 1; any = 0;
      a = 1;
      forever begin
        r = r0 + dr*a;
        c = c0 + dc*a;
        if (r < 0 || c < 0 || r >= eff_rows() || c >= eff_cols()) break;
        z = grid[r*GRID_DIM + c];
        dz = z - z0;
        if (z != nodata_elev && ((dz < 0) ? -dz : dz) > best) begin
          best = (dz < 0) ? -dz : dz;
          if (!any) begin
            mxz = dz; mxa = a; mnz = dz; mna = a; any = 1;
          end else begin
            if (dz*mxa > mxz*a) begin mxz = dz; mxa = a; end
            if (dz*mna < mnz*a) begin mnz = dz; mna = a; end
          end
        end
        a++;
      end
      if (!any) return DIG_EQUAL;
      s = mxz*mna + mnz*mxa;
      return (s > 0) ? DIG_HIGHER : ((s < 0) ? DIG_LOWER : DIG_EQUAL);
    endfunction

    function void note_input(logic func, int r, int c, logic [23:0] elev);
      terrain_result_t res;
      digit_t d[NUM_RAYS];
      int best, code, idx;
      if (func == FUNC_WRITE) begin
        grid[r*GRID_DIM + c] = int'(signed'(elev));
        return;
      end
      res = '{code: '0, higher: '0, lower: '0, no_data: 1'b1};
      if (r >= 1 && c >= 1 && r + 1 < eff_rows() && c + 1 < eff_cols() &&
          grid[r*GRID_DIM + c] != nodata_elev) begin
        res.no_data = 1'b0;
        for (int k = 0; k < NUM_RAYS; k++) begin
          d[k] = ray_sign(r, c, k);
          if (d[k] == DIG_HIGHER) res.higher++;
          if (d[k] == DIG_LOWER) res.lower++;
        end
        // minimum over rotations and mirror; unrotated, ray 7 is most significant
        best = 32'h7fffffff;
        for (int m = 0; m < 2; m++)
          for (int j = 0; j < 8; j++) begin
            code = 0;
            for (int i = 7; i >= 0; i--) begin
              idx = m ? ((7 - i + j) & 7) : ((i + j) & 7);
              code = code*3 + int'(d[idx]);
            end
            if (code < best) best = code;
          end
        res.code = best[CODE_W-1:0];
      end
      pending.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [CODE_W-1:0] code, logic [CNT_W-1:0] hi,
                      logic [CNT_W-1:0] lo, logic nd);
      terrain_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no classify pending");
        return;
      end
      e = pending.pop_front();
      if (nd !== e.no_data)
        report_mismatch($sformatf("no_data %b, expected %b", nd, e.no_data));
      if (code !== e.code)
        report_mismatch($sformatf("pattern_code %0d, expected %0d", code, e.code));
      if (hi !== e.higher)
        report_mismatch($sformatf("higher_count %0d, expected %0d", hi, e.higher));
      if (lo !== e.lower)
        report_mismatch($sformatf("lower_count %0d, expected %0d", lo, e.lower));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_func;
  logic [POS_W-1:0]     in_row;
  logic [POS_W-1:0]     in_col;
  logic signed [23:0]   in_elevation;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 out_valid;
  logic [CODE_W-1:0]    out_pattern_code;
  logic [CNT_W-1:0]     out_higher_count;
  logic [CNT_W-1:0]     out_lower_count;
  logic                 out_no_data;

  tpc_scoreboard sb = new();
  bit written[GRID_DIM*GRID_DIM];
  int item_count;
  int elev_base;
  bit no_gaps;

  terrain_pattern_classifier dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_row(in_row), .in_col(in_col), .in_elevation(in_elevation),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_pattern_code(out_pattern_code),
    .out_higher_count(out_higher_count), .out_lower_count(out_lower_count),
    .out_no_data(out_no_data)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  always @(posedge clk)
    if (rst_n && out_valid)
      sb.check_result(out_pattern_code, out_higher_count, out_lower_count, out_no_data);

  // Called at a rising edge; returns at the edge that accepted the item.
  task send_item(logic func, int r, int c, logic [23:0] elev);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= func;
    in_row       <= r[POS_W-1:0];
    in_col       <= c[POS_W-1:0];
    in_elevation <= elev;
    do @(posedge clk); while (busy);
    sb.note_input(func, r, c, elev);
    item_count++;
  endtask

  function logic [23:0] pick_elev();
    int v;
    case ($urandom_range(0, 11))
      0: v = sb.nodata_elev;
      1: v = $urandom;
      2: v = $urandom_range(0, 1) ? 8388607 : -8388608;
      3: v = elev_base + int'($urandom_range(0, 400)) - 200;
      default: v = elev_base + int'($urandom_range(0, 6)) - 3;
    endcase
    return v[23:0];
  endfunction

  task write_cell(int r, int c, logic [23:0] elev);
    written[r*GRID_DIM + c] = 1'b1;
    send_item(FUNC_WRITE, r, c, elev);
  endtask

  // Interior: fills unwritten center and, if it has data, ray cells; always classifies.
  task classify_at(int r, int c);
    int rr, cc, dr, dc;
    if (r >= 1 && c >= 1 && r + 1 < sb.eff_rows() && c + 1 < sb.eff_cols()) begin
      if (!written[r*GRID_DIM + c]) write_cell(r, c, pick_elev());
      if (sb.grid[r*GRID_DIM + c] != sb.nodata_elev)
        for (int k = 0; k < NUM_RAYS; k++) begin
          dr = (k >= 1 && k <= 3) ? 1 : ((k >= 5) ? -1 : 0);
          dc = (k == 0 || k == 1 || k == 7) ? 1 : ((k >= 3 && k <= 5) ? -1 : 0);
          rr = r + dr; cc = c + dc;
          while (rr >= 0 && cc >= 0 && rr < sb.eff_rows() && cc < sb.eff_cols()) begin
            if (!written[rr*GRID_DIM + cc]) write_cell(rr, cc, pick_elev());
            rr += dr; cc += dc;
          end
        end
    end
    send_item(FUNC_CLASSIFY, r, c, 24'($urandom));
  endtask

  // Block idle: nothing pending, busy low, plus margin for a trailing write.
  task wait_idle();
    @(posedge clk);
    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_cfg(idx, data);
  endtask

  task set_grid(int rows, int cols, int nodata);
    wait_idle();
    cfg_write(CFG_ROW_COUNT, rows[CFG_W-1:0]);
    cfg_write(CFG_COL_COUNT, cols[CFG_W-1:0]);
    cfg_write(CFG_NODATA, nodata[CFG_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  function int pick_count();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 2);
      1: return 64;
      2: return $urandom_range(65, 127);
      3: return $urandom_range(13, 40);
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int nd, n, r, c;
    start = 1'b0; in_func = FUNC_WRITE; in_row = '0; in_col = '0; in_elevation = '0;
    cfg_we = 1'b0; cfg_index = CFG_ROW_COUNT; cfg_data = '0;
    rst_n = 1'b0; item_count = 0; elev_base = 0; no_gaps = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: borders under reset config, then a 3x3 grid with extremes and a 4x3 grid
    send_item(FUNC_CLASSIFY, 0, 0, '0);
    send_item(FUNC_CLASSIFY, 63, 63, '0);
    send_item(FUNC_CLASSIFY, 0, 30, '0);
    set_grid(3, 3, 0);
    write_cell(1, 1, 24'd0);
    send_item(FUNC_CLASSIFY, 1, 1, '0);          // center equals no-data marker
    send_item(FUNC_CLASSIFY, 2, 1, '0);          // last row in use
    write_cell(1, 1, 24'd5);
    write_cell(0, 0, 24'h7fffff);
    write_cell(0, 1, 24'h800000);
    write_cell(0, 2, 24'd0);                    // skipped as no-data
    write_cell(1, 0, 24'd5);
    write_cell(1, 2, 24'd9);
    write_cell(2, 0, 24'd1);
    write_cell(2, 1, 24'hfffffe);
    write_cell(2, 2, 24'd5);
    send_item(FUNC_CLASSIFY, 1, 1, '0);
    set_grid(3, 3, -8388608);
    send_item(FUNC_CLASSIFY, 1, 1, '0);
    set_grid(4, 3, 8388607);
    classify_at(1, 1);
    classify_at(2, 1);

    // random phases
    while (item_count < 1170) begin
      nd = $urandom_range(0, 3) == 0 ? -9999 :
           ($urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 8388607 : -8388608)
                                      : int'($urandom_range(0, 200)) - 100);
      set_grid(pick_count(), pick_count(), nd);
      elev_base = int'($urandom_range(0, 200000)) - 100000;
      no_gaps = ($urandom_range(0, 4) == 0);
      n = $urandom_range(20, 60);
      for (int i = 0; i < n && item_count < 1170; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                         : $urandom_range(0, (sb.eff_rows() < 63) ?
                                                              sb.eff_rows() : 63);
          c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                         : $urandom_range(0, (sb.eff_cols() < 63) ?
                                                              sb.eff_cols() : 63);
          classify_at(r, c);
        end else if ($urandom_range(0, 3) == 0) begin
          write_cell($urandom_range(0, 63), $urandom_range(0, 63), pick_elev());
        end else begin
          write_cell($urandom_range(0, sb.eff_rows() > 0 ? sb.eff_rows() - 1 : 0),
                     $urandom_range(0, sb.eff_cols() > 0 ? sb.eff_cols() - 1 : 0),
                     pick_elev());
        end
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### sim.f
src/tpc_pkg.sv
src/tpc_pattern_min.sv
src/terrain_pattern_classifier.sv
bench/tb_terrain_pattern_classifier.sv
